// File: rtl/qet_pkg.sv
// shared types, constants and codes for the quadric error table
package qet_pkg;

	localparam int VERTICES    = 1024;
	localparam int VW          = 10;
	localparam int NCOEF       = 10;
	localparam int STORE_DEPTH = VERTICES * NCOEF;
	localparam int SAW         = $clog2(STORE_DEPTH);
	localparam int CW          = 64;
	localparam int ACCW        = 128;
	localparam int PW          = 50;
	localparam int MAW         = 33;
	localparam int MBW         = 26;
	localparam int MPW         = MAW + MBW;

	typedef logic signed [MAW-1:0] mul_a_t;
	typedef logic signed [MBW-1:0] mul_b_t;
	typedef logic signed [MPW-1:0] mul_p_t;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_EVAL = 2'd1,
		OP_CLR  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [10:0] {
		S_INIT = 11'b000_0000_0001,
		S_IDLE = 11'b000_0000_0010,
		S_ADD  = 11'b000_0000_0100,
		S_ADDW = 11'b000_0000_1000,
		S_FLAG = 11'b000_0001_0000,
		S_CLR  = 11'b000_0010_0000,
		S_PROD = 11'b000_0100_0000,
		S_RD   = 11'b000_1000_0000,
		S_MUL  = 11'b001_0000_0000,
		S_FIN  = 11'b010_0000_0000,
		S_OUT  = 11'b100_0000_0000
	} state_t;

endpackage

// File: rtl/qet_ram.sv
// generic single write, single registered read memory
module qet_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/qet_mul.sv
// shared signed multiplier with registered product
module qet_mul (
	input  logic           clk,
	input  qet_pkg::mul_a_t a,
	input  qet_pkg::mul_b_t b,
	output qet_pkg::mul_p_t prod
);
	import qet_pkg::*;

	// one product per cycle, operands widened to the full product width
	always_ff @(posedge clk) begin
		prod <= mul_p_t'(a) * mul_p_t'(b);
	end
endmodule

// File: rtl/quadric_error_table_core.sv
// quadric error table top level: sequencer, store and evaluation datapath
// An evaluate raises done in the cycle following its last busy cycle.
// Throughput: one transaction at a time; busy stays high for the whole operation.
// Evaluation uses the shared 33x26 multiplier: six position products then four
// partial products per coefficient. After reset a clearing pass zeroes the store
// (one coefficient a cycle) with busy high; done cannot be held off by the receiver.
module quadric_error_table_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic [qet_pkg::VW-1:0]  vertex,
	input  logic signed [15:0]      plane_a,
	input  logic signed [15:0]      plane_b,
	input  logic signed [15:0]      plane_c,
	input  logic signed [23:0]      plane_d,
	input  logic signed [23:0]      pos_x,
	input  logic signed [23:0]      pos_y,
	input  logic signed [23:0]      pos_z,
	output logic                    done,
	output logic [qet_pkg::VW-1:0]  vertex_echo,
	output logic signed [63:0]      error_value,
	output logic                    saturated
);
	import qet_pkg::*;

	state_t               state_q;
	logic [SAW-1:0]       clr_q;
	logic [3:0]           cnt_q;
	logic [1:0]           sub_q;
	logic                 sat_q;
	logic                 add_v_s1;
	logic                 prod_v_s1;
	logic                 acc_v_s1;
	logic [3:0]           idx_s1;
	logic [1:0]           sh_s1;
	logic [VW-1:0]        vert_q;
	logic [SAW-1:0]       base_q;
	logic signed [15:0]   a_q, b_q, c_q;
	logic signed [23:0]   d_q, x_q, y_q, z_q;
	logic signed [PW-1:0] pp_q [6];
	logic [ACCW-1:0]      acc_q;
	logic                 done_q;
	logic [VW-1:0]        echo_q;
	logic [CW-1:0]        err_q;
	logic                 satout_q;

	mul_a_t               mul_a;
	mul_b_t               mul_b;
	mul_p_t               prod;
	logic                 st_we;
	logic [SAW-1:0]       st_waddr;
	logic [CW-1:0]        st_wdata;
	logic [SAW-1:0]       st_raddr;
	logic [CW-1:0]        st_rdata;
	logic                 fl_we;
	logic [VW-1:0]        fl_waddr;
	logic                 fl_wdata;
	logic                 fl_rdata;
	logic signed [CW-1:0] term;
	logic [CW-1:0]        sum;
	logic                 ovf;
	logic signed [PW-1:0] pval;
	logic [ACCW-1:0]      addend;
	logic [99:0]          fl_r;
	logic                 fits;
	logic [SAW-1:0]       start_base;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign vertex_echo = echo_q;
	assign error_value = err_q;
	assign saturated   = satout_q;
	assign start_base  = SAW'({vertex, 3'b000}) + SAW'({vertex, 1'b0});

	// coefficient store and sticky saturation flags
	qet_ram #(.WIDTH(CW), .DEPTH(STORE_DEPTH)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	qet_ram #(.WIDTH(1), .DEPTH(VERTICES)) u_flags (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(vert_q), .rdata(fl_rdata)
	);

	qet_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	// evaluation weight for the coefficient under work
	always_comb begin
		case (cnt_q)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: pval = pp_q[cnt_q[2:0]];
			4'd6:    pval = PW'(x_q) <<< 15;
			4'd7:    pval = PW'(y_q) <<< 15;
			4'd8:    pval = PW'(z_q) <<< 15;
			default: pval = PW'(1) <<< 28;
		endcase
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ADD: begin
				case (cnt_q)
					4'd0: begin mul_a = MAW'(a_q); mul_b = MBW'(a_q); end
					4'd1: begin mul_a = MAW'(a_q); mul_b = MBW'(b_q); end
					4'd2: begin mul_a = MAW'(b_q); mul_b = MBW'(b_q); end
					4'd3: begin mul_a = MAW'(a_q); mul_b = MBW'(c_q); end
					4'd4: begin mul_a = MAW'(b_q); mul_b = MBW'(c_q); end
					4'd5: begin mul_a = MAW'(c_q); mul_b = MBW'(c_q); end
					4'd6: begin mul_a = MAW'(a_q); mul_b = MBW'(d_q); end
					4'd7: begin mul_a = MAW'(b_q); mul_b = MBW'(d_q); end
					4'd8: begin mul_a = MAW'(c_q); mul_b = MBW'(d_q); end
					default: begin mul_a = MAW'(d_q); mul_b = MBW'(d_q); end
				endcase
			end
			S_PROD: begin
				case (cnt_q)
					4'd0: begin mul_a = MAW'(x_q); mul_b = MBW'(x_q); end
					4'd1: begin mul_a = MAW'(x_q); mul_b = MBW'(y_q); end
					4'd2: begin mul_a = MAW'(y_q); mul_b = MBW'(y_q); end
					4'd3: begin mul_a = MAW'(x_q); mul_b = MBW'(z_q); end
					4'd4: begin mul_a = MAW'(y_q); mul_b = MBW'(z_q); end
					default: begin mul_a = MAW'(z_q); mul_b = MBW'(z_q); end
				endcase
			end
			S_MUL: begin
				case (sub_q)
					2'd0: begin
						mul_a = {1'b0, st_rdata[31:0]};
						mul_b = {1'b0, pval[24:0]};
					end
					2'd1: begin
						mul_a = {1'b0, st_rdata[31:0]};
						mul_b = MBW'($signed(pval[49:25]));
					end
					2'd2: begin
						mul_a = MAW'($signed(st_rdata[63:32]));
						mul_b = {1'b0, pval[24:0]};
					end
					default: begin
						mul_a = MAW'($signed(st_rdata[63:32]));
						mul_b = MBW'($signed(pval[49:25]));
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// saturating coefficient update
	always_comb begin
		term = CW'(prod);
		sum  = st_rdata + term;
		ovf  = (st_rdata[63] == term[63]) && (sum[63] != st_rdata[63]);
	end

	// shifted partial product for the accumulator
	always_comb begin
		case (sh_s1)
			2'd0:    addend = ACCW'(prod);
			2'd1:    addend = ACCW'(prod) << 25;
			2'd2:    addend = ACCW'(prod) << 32;
			default: addend = ACCW'(prod) << 57;
		endcase
	end

	// floor to 2^-16 scale and range check
	assign fl_r = acc_q[127:28];
	assign fits = (&fl_r[99:63]) | ~(|fl_r[99:63]);

	// store port control
	assign st_raddr = base_q + SAW'(cnt_q);
	always_comb begin
		st_we    = 1'b0;
		st_waddr = base_q + SAW'(idx_s1);
		st_wdata = '0;
		fl_we    = 1'b0;
		fl_waddr = vert_q;
		fl_wdata = 1'b0;
		case (state_q)
			S_INIT: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				fl_we    = (clr_q < SAW'(VERTICES));
				fl_waddr = clr_q[VW-1:0];
			end
			S_ADD, S_ADDW: begin
				st_we    = add_v_s1;
				st_wdata = ovf ? (st_rdata[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum;
			end
			S_FLAG: begin
				fl_we    = sat_q;
				fl_wdata = 1'b1;
			end
			S_CLR: begin
				st_we    = 1'b1;
				st_waddr = base_q + SAW'(cnt_q);
				fl_we    = (cnt_q == 4'd0);
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			clr_q     <= '0;
			cnt_q     <= '0;
			sub_q     <= '0;
			sat_q     <= 1'b0;
			add_v_s1  <= 1'b0;
			prod_v_s1 <= 1'b0;
			acc_v_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			add_v_s1  <= (state_q == S_ADD);
			prod_v_s1 <= (state_q == S_PROD);
			acc_v_s1  <= (state_q == S_MUL);
			done_q    <= (state_q == S_OUT);
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SAW'(STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					sub_q <= '0;
					sat_q <= 1'b0;
					if (start) begin
						case (operation)
							OP_ADD:  state_q <= S_ADD;
							OP_EVAL: state_q <= S_PROD;
							OP_CLR:  state_q <= S_CLR;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD: begin
					if (add_v_s1 && ovf) begin
						sat_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(NCOEF - 1)) begin
						state_q <= S_ADDW;
					end
				end
				S_ADDW: begin
					if (ovf) begin
						sat_q <= 1'b1;
					end
					state_q <= S_FLAG;
				end
				S_FLAG: begin
					state_q <= S_IDLE;
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(NCOEF - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_PROD: begin
					if (cnt_q == 4'd5) begin
						cnt_q   <= '0;
						state_q <= S_RD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RD: begin
					sub_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd3) begin
						if (cnt_q == 4'(NCOEF - 1)) begin
							state_q <= S_FIN;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand capture, products and accumulator
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		sh_s1  <= sub_q;
		if (state_q == S_IDLE && start) begin
			vert_q <= vertex;
			base_q <= start_base;
			a_q    <= plane_a;
			b_q    <= plane_b;
			c_q    <= plane_c;
			d_q    <= plane_d;
			x_q    <= pos_x;
			y_q    <= pos_y;
			z_q    <= pos_z;
			acc_q  <= '0;
		end else if (acc_v_s1) begin
			acc_q <= acc_q + addend;
		end
		if (prod_v_s1) begin
			if (idx_s1 == 4'd1 || idx_s1 == 4'd3 || idx_s1 == 4'd4) begin
				pp_q[idx_s1[2:0]] <= PW'(prod) <<< 1;
			end else begin
				pp_q[idx_s1[2:0]] <= PW'(prod);
			end
		end
		if (state_q == S_OUT) begin
			echo_q   <= vert_q;
			satout_q <= ~fits | fl_rdata;
			if (fits) begin
				err_q <= fl_r[63:0];
			end else begin
				err_q <= fl_r[99] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			end
		end
	end

	// checks on sequencing
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_EVAL) |=> busy)
		else $error("evaluate transaction did not hold busy");
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !st_we) else $error("store written while idle");
	a_acc_window: assert property (@(posedge clk) disable iff (!arst_n)
		acc_v_s1 |-> (state_q == S_RD || state_q == S_MUL || state_q == S_FIN))
		else $error("accumulate outside evaluation");
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_OUT)) else $error("result without evaluation");
endmodule
